### sv/gmp_pkg.sv
// ----------------------------------------------------------------------------
// gmp_pkg
// Types and constants shared by the gradient magnitude and phase unit.
// ----------------------------------------------------------------------------
package gmp_pkg;

  localparam int IN_W     = 16;
  localparam int MAG_W    = 15;
  localparam int PH_W     = 8;
  localparam int STEPS    = 17;   // quotient bits and (padded) root bits

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_MAG_NORM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_RANGE = 2'd1;

  localparam logic [14:0] MAG_MAX = 15'd32767;
  localparam logic [14:0] K_C2    = 15'd16037;
  localparam logic [12:0] K_C1    = 13'd4345;
  localparam logic [15:0] K_PI4   = 16'd51472;
  localparam logic [21:0] K_DEG   = 22'd3754936;
  localparam logic [15:0] RND16   = 16'd32768;
  localparam logic [25:0] Q90     = 26'd5898240;
  localparam logic [25:0] Q180    = 26'd11796480;
  localparam logic [25:0] Q360    = 26'd23592960;
  // floor(2^24 / 360), quotient may come out one low
  localparam logic [15:0] INV360  = 16'd46603;
  localparam logic [16:0] DEG360  = 17'd360;
  localparam logic [16:0] DEG180  = 17'd180;

  typedef struct packed {
    logic [15:0] rem;    // division remainder
    logic [16:0] nbits;  // dividend bits still to shift in
    logic [16:0] q;      // quotient so far
    logic [15:0] hi;     // divisor
    logic [33:0] sbits;  // radicand bits still to shift in
    logic [17:0] srem;   // root remainder
    logic [16:0] root;   // root so far
  } cell_t;

  typedef struct packed {
    logic        gx_neg;
    logic        gy_neg;
    logic        swap;
    logic        hi_zero;
    logic [14:0] l1;
  } side_t;

endpackage

### sv/gmp_in_if.sv
// ----------------------------------------------------------------------------
// gmp_in_if
// Input channel: one gradient pair per item.
// ----------------------------------------------------------------------------
interface gmp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] gx_value;
  logic signed [15:0] gy_value;
  modport source(output valid, gx_value, gy_value, input ready);
  modport sink(input valid, gx_value, gy_value, output ready);
endinterface

### sv/gmp_out_if.sv
// ----------------------------------------------------------------------------
// gmp_out_if
// Result channel: magnitude and phase per item.
// ----------------------------------------------------------------------------
interface gmp_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] magnitude;
  logic [7:0]  phase_angle;
  modport source(output valid, magnitude, phase_angle, input ready);
  modport sink(input valid, magnitude, phase_angle, output ready);
endinterface

### sv/gmp_cfg_if.sv
// ----------------------------------------------------------------------------
// gmp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface gmp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### sv/gmp_front.sv
// ----------------------------------------------------------------------------
// gmp_front
// Absolute values, L1 sum, squares and divider/root setup.
// ----------------------------------------------------------------------------
module gmp_front #(
  parameter int GRAD_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_v,
  input  logic [15:0]         gx_raw,
  input  logic [15:0]         gy_raw,
  output logic                out_v,
  output gmp_pkg::cell_t      chain_d,
  output gmp_pkg::side_t      side
);
  import gmp_pkg::*;

  logic signed [16:0] gx_s, gy_s;
  logic [16:0] ax, ay, ax_r, ay_r;
  logic [17:0] sum;
  side_t       side0;
  logic        v0;
  logic [16:0] lo, hi;
  logic [31:0] num;
  logic [33:0] sq;

  assign gx_s = {{(17-GRAD_WIDTH){gx_raw[GRAD_WIDTH-1]}}, gx_raw[GRAD_WIDTH-1:0]};
  assign gy_s = {{(17-GRAD_WIDTH){gy_raw[GRAD_WIDTH-1]}}, gy_raw[GRAD_WIDTH-1:0]};
  assign ax   = gx_s[16] ? 17'(-gx_s) : 17'(gx_s);
  assign ay   = gy_s[16] ? 17'(-gy_s) : 17'(gy_s);
  assign sum  = 18'(ax) + 18'(ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v0    <= in_v;
      out_v <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax_r          <= ax;
      ay_r          <= ay;
      side0.gx_neg  <= gx_s[16];
      side0.gy_neg  <= gy_s[16];
      side0.swap    <= ax < ay;
      side0.hi_zero <= (ax == 17'd0) && (ay == 17'd0);
      side0.l1      <= (sum > 18'(MAG_MAX)) ? MAG_MAX : sum[14:0];
    end
  end

  assign lo  = side0.swap ? ax_r : ay_r;
  assign hi  = side0.swap ? ay_r : ax_r;
  // z dividend: lo*2^16 + hi/2, below 2^32 since lo <= 32768
  assign num = 32'({lo, 16'd0}) + 32'(hi >> 1);
  assign sq  = 34'(ax_r * ax_r) + 34'(ay_r * ay_r);

  always_ff @(posedge clk) begin
    if (en) begin
      side          <= side0;
      chain_d.rem   <= 16'(num[31:17]);
      chain_d.nbits <= num[16:0];
      chain_d.q     <= '0;
      chain_d.hi    <= hi[15:0];
      chain_d.sbits <= sq;
      chain_d.srem  <= '0;
      chain_d.root  <= '0;
    end
  end

endmodule

### sv/gmp_cell.sv
// ----------------------------------------------------------------------------
// gmp_cell
// One restoring divide step and one restoring square root step.
// ----------------------------------------------------------------------------
module gmp_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_v,
  input  gmp_pkg::cell_t d_in,
  input  gmp_pkg::side_t s_in,
  output logic           out_v,
  output gmp_pkg::cell_t d_out,
  output gmp_pkg::side_t s_out
);
  import gmp_pkg::*;

  logic [16:0] r2;
  logic [19:0] rem2, trial;
  cell_t       nxt;

  always_comb begin
    nxt       = d_in;
    r2        = {d_in.rem, d_in.nbits[16]};
    nxt.nbits = {d_in.nbits[15:0], 1'b0};
    if (r2 >= 17'(d_in.hi)) begin
      nxt.rem = 16'(r2 - 17'(d_in.hi));
      nxt.q   = {d_in.q[15:0], 1'b1};
    end else begin
      nxt.rem = r2[15:0];
      nxt.q   = {d_in.q[15:0], 1'b0};
    end
    rem2      = {d_in.srem, d_in.sbits[33:32]};
    trial     = {1'b0, d_in.root, 2'b01};
    nxt.sbits = {d_in.sbits[31:0], 2'b00};
    if (rem2 >= trial) begin
      nxt.srem = 18'(rem2 - trial);
      nxt.root = {d_in.root[15:0], 1'b1};
    end else begin
      nxt.srem = rem2[17:0];
      nxt.root = {d_in.root[15:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= nxt;
      s_out <= s_in;
    end
  end

endmodule

### sv/gmp_back.sv
// ----------------------------------------------------------------------------
// gmp_back
// Magnitude rounding, atan polynomial, folding and output formatting.
// ----------------------------------------------------------------------------
module gmp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           out_en,
  input  logic           in_v,
  input  gmp_pkg::cell_t d_in,
  input  gmp_pkg::side_t s_in,
  input  logic           magnitude_norm,
  input  logic           phase_range,
  output logic           last_v,
  output logic           out_v,
  output logic [14:0]    magnitude,
  output logic [7:0]     phase_angle
);
  import gmp_pkg::*;

  logic [6:0]  v;
  logic [14:0] mag [0:6];
  side_t       sd  [0:5];

  logic [16:0] z, root_r;
  logic [29:0] m1;
  logic [33:0] m2;
  logic [32:0] m3;
  logic [14:0] p, t;
  logic [15:0] k, k2;
  logic [29:0] pt;
  logic [16:0] rad;
  logic [38:0] dp;
  logic [24:0] a;
  logic [22:0] deg;
  logic signed [25:0] f1, f2, f3;
  logic [24:0] au;
  logic [7:0]  phu;
  logic [16:0] x;
  logic [8:0]  q0;
  logic [16:0] xr;
  logic [8:0]  qf;

  assign z      = d_in.q;
  assign root_r = d_in.root + 17'(d_in.srem > 18'(d_in.root));

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[5:0], in_v};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: products on z, magnitude pick
      m1     <= 30'(K_C1 * (s_in.hi_zero ? 17'd0 : z));
      m2     <= 34'((s_in.hi_zero ? 17'd0 : z) * 17'(17'h10000 - (s_in.hi_zero ? 17'd0 : z)));
      m3     <= 33'(K_PI4 * (s_in.hi_zero ? 17'd0 : z));
      sd[0]  <= s_in;
      mag[0] <= !magnitude_norm ? s_in.l1 :
                (root_r > 17'(MAG_MAX)) ? MAG_MAX : root_r[14:0];
      // stage 1: round products
      p      <= K_C2 + 15'((34'(m1) + 34'(RND16)) >> 16);
      t      <= 15'((m2 + 34'(RND16)) >> 16);
      k      <= 16'((m3 + 33'(RND16)) >> 16);
      // stage 2
      pt     <= 30'(p * t);
      k2     <= k;
      // stage 3
      rad    <= 17'(k2) + 17'((31'(pt) + 31'(RND16)) >> 16);
      // stage 4
      dp     <= 39'(rad * K_DEG);
      // stage 5: octant and quadrant fold
      a      <= (f3 < 0) ? 25'd0 : 25'(f3);
      // stage 6: unsigned rounding, signed reciprocal estimate
      phu    <= 8'((au + 25'(RND16)) >> 16);
      x      <= 17'(a >> 8) + DEG180;
      q0     <= 9'((33'(17'(a >> 8) + DEG180) * 33'(INV360)) >> 24);
      for (int i = 1; i < 7; i++) begin
        mag[i] <= mag[i-1];
      end
      for (int i = 1; i < 6; i++) begin
        sd[i] <= sd[i-1];
      end
    end
  end

  assign deg = 23'((dp + 39'(RND16)) >> 16);
  assign f1  = sd[4].swap   ? $signed(Q90)  - $signed(26'(deg)) : $signed(26'(deg));
  assign f2  = sd[4].gx_neg ? $signed(Q180) - f1 : f1;
  assign f3  = sd[4].gy_neg ? $signed(Q360) - f2 : f2;
  assign au  = (26'(a) > Q180) ? 25'(26'(a) - Q180) : a;

  // quotient correction: estimate is exact or one low
  assign xr  = x - 17'(q0 * 9'd360);
  assign qf  = (xr >= DEG360) ? q0 + 9'd1 : q0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (out_en) begin
      out_v <= v[6];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      magnitude   <= mag[6];
      phase_angle <= phase_range ? phu : qf[7:0];
    end
  end

  assign last_v = v[6];

endmodule

### sv/gradient_magnitude_phase_unit.sv
// Input to result: 2 setup, 17 pipelined divide/root cells, 8 back-end stages.
// Throughput: one item per cycle unless a held result blocks the pipe.
// Reset clears all valid bits and loads magnitude_norm = 1 (L2), phase_range = 0.
// ----------------------------------------------------------------------------
// gradient_magnitude_phase_unit
// Gradient magnitude (L1/L2) and fast atan2 phase per pixel.
// ----------------------------------------------------------------------------
module gradient_magnitude_phase_unit #(
  parameter int GRAD_WIDTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  gmp_in_if.sink    in_ch,
  gmp_out_if.source out_ch,
  gmp_cfg_if.sink   cfg
);
  import gmp_pkg::*;

  logic magnitude_norm, phase_range;
  logic en, out_en, last_v;

  logic  cv [0:STEPS];
  cell_t cd [0:STEPS];
  side_t cs [0:STEPS];

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude_norm <= 1'b1;
      phase_range    <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAG_NORM:    magnitude_norm <= cfg.data[0];
        REG_PHASE_RANGE: phase_range    <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // output register loads when free; the pipe also moves when nothing reaches it
  assign out_en      = !out_ch.valid || out_ch.ready;
  assign en          = out_en || !last_v;
  assign in_ch.ready = en;

  gmp_front #(.GRAD_WIDTH(GRAD_WIDTH)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_v(in_ch.valid), .gx_raw(in_ch.gx_value), .gy_raw(in_ch.gy_value),
    .out_v(cv[0]), .chain_d(cd[0]), .side(cs[0])
  );

  for (genvar g = 0; g < STEPS; g++) begin : g_cell
    gmp_cell u_cell (
      .clk(clk), .rst(rst), .en(en),
      .in_v(cv[g]), .d_in(cd[g]), .s_in(cs[g]),
      .out_v(cv[g+1]), .d_out(cd[g+1]), .s_out(cs[g+1])
    );
  end

  gmp_back u_back (
    .clk(clk), .rst(rst), .en(en), .out_en(out_en),
    .in_v(cv[STEPS]), .d_in(cd[STEPS]), .s_in(cs[STEPS]),
    .magnitude_norm(magnitude_norm), .phase_range(phase_range),
    .last_v(last_v), .out_v(out_ch.valid),
    .magnitude(out_ch.magnitude), .phase_angle(out_ch.phase_angle)
  );

  a_stall_only_on_held_result: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without a held result");

  a_unsigned_phase_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && phase_range |-> out_ch.phase_angle <= 8'd180)
    else $error("unsigned phase above 180");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.magnitude) &&
    $stable(out_ch.phase_angle))
    else $error("result item changed while waiting");

endmodule
